FILE: sv/pep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_pkg
// Shared types, constants and helpers of the postfix evaluator.
// ----------------------------------------------------------------------------
package pep_pkg;

  localparam int STACK_DEPTH  = 32;
  localparam int NUM_VARS     = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int FRONT_DEPTH  = 2;
  localparam int OUTQ_DEPTH   = 2;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int VAR_IW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int FQ_PW  = $clog2(FRONT_DEPTH);
  localparam int FQ_CW  = $clog2(FRONT_DEPTH + 1);
  localparam int OQ_PW  = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW  = $clog2(OUTQ_DEPTH + 1);

  localparam int XW = 34;  // CORDIC x/y, Q8.24 plus headroom
  localparam int ZW = 30;  // CORDIC angle, Q6.24
  localparam int MW = 40;  // angle magnitude before reduction
  localparam int RED_STEPS = 13;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic [MW-1:0] TWO_PI_Q24 = 40'd105414357;
  localparam logic signed [ZW-1:0] PI_Q24 = 30'sd52707179;
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [XW-1:0] GAIN_Q24 = 34'sd10188014;
  localparam logic [MW-1:0] RED_TOP = TWO_PI_Q24 << (RED_STEPS - 1);

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_SQRT = 4'd4, OP_SIN = 4'd5, OP_COS = 4'd6, OP_CONST = 4'd7,
    OP_VAR = 4'd8, OP_SETVAR = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    CL_BIN, CL_UNA, CL_PUSHC, CL_PUSHV, CL_SETV, CL_BAD
  } cls_t;

  typedef enum logic [2:0] {
    AOP_ADD, AOP_SUB, AOP_MUL, AOP_DIV, AOP_SQRT, AOP_SIN, AOP_COS
  } alu_op_t;

  typedef enum logic [3:0] {
    AL_IDLE, AL_MUL, AL_DIV, AL_QFIN, AL_SQRT, AL_RED, AL_FOLD, AL_CORD,
    AL_TFIN, AL_DONE
  } alu_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DEC, B_RDA, B_RDB, B_EXEC, B_WAIT, B_LAST, B_LRD, B_EMIT
  } back_state_t;

  typedef struct packed {
    cls_t               cls;
    alu_op_t            aop;
    logic signed [31:0] operand;
    logic [2:0]         idx;
    logic signed [31:0] target;
    logic               last;
  } tok_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [30:0]        abs_err;
    logic               err;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // atan(2^-i) in Q6.24
  function automatic logic signed [ZW-1:0] atan_q24(input logic [5:0] i);
    logic [ZW-1:0] one;
    one = ZW'(1);
    case (i)
      6'd0: atan_q24 = 30'sd13176795;
      6'd1: atan_q24 = 30'sd7778716;
      6'd2: atan_q24 = 30'sd4110060;
      6'd3: atan_q24 = 30'sd2086331;
      6'd4: atan_q24 = 30'sd1047214;
      6'd5: atan_q24 = 30'sd524117;
      6'd6: atan_q24 = 30'sd262123;
      6'd7: atan_q24 = 30'sd131069;
      default: begin
        if (i <= 6'd24) atan_q24 = signed'(one << (6'd24 - i));
        else atan_q24 = '0;
      end
    endcase
  endfunction

endpackage

FILE: sv/pep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_front
// Token intake: decodes each opcode into a class and queues the token.
// ----------------------------------------------------------------------------
module pep_front
  import pep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand_value,
  input  logic [2:0]         in_var_index,
  input  logic signed [31:0] in_target_value,
  input  logic               in_last_token,
  input  logic               in_push,
  output logic               in_full,
  output logic               tok_valid,
  output tok_t               tok,
  input  logic               tok_pop
);

  tok_t             q_r [FRONT_DEPTH];
  logic [FQ_PW-1:0] wp_r, rp_r;
  logic [FQ_CW-1:0] cnt_r;
  tok_t             dec;
  logic             wr, rd;

  always_comb begin
    dec.operand = in_operand_value;
    dec.idx     = in_var_index;
    dec.target  = in_target_value;
    dec.last    = in_last_token;
    dec.aop     = AOP_ADD;
    unique case (in_opcode) inside
      OP_ADD:    begin dec.cls = CL_BIN; dec.aop = AOP_ADD;  end
      OP_SUB:    begin dec.cls = CL_BIN; dec.aop = AOP_SUB;  end
      OP_MUL:    begin dec.cls = CL_BIN; dec.aop = AOP_MUL;  end
      OP_DIV:    begin dec.cls = CL_BIN; dec.aop = AOP_DIV;  end
      OP_SQRT:   begin dec.cls = CL_UNA; dec.aop = AOP_SQRT; end
      OP_SIN:    begin dec.cls = CL_UNA; dec.aop = AOP_SIN;  end
      OP_COS:    begin dec.cls = CL_UNA; dec.aop = AOP_COS;  end
      OP_CONST:  dec.cls = CL_PUSHC;
      OP_VAR:    dec.cls = CL_PUSHV;
      OP_SETVAR: dec.cls = CL_SETV;
      default:   dec.cls = CL_BAD;
    endcase
  end

  assign in_full   = (cnt_r == FQ_CW'(FRONT_DEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = q_r[rp_r];
  assign wr        = in_push && !in_full;
  assign rd        = tok_pop && tok_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + FQ_CW'(wr) - FQ_CW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= dec;
  end

endmodule

FILE: sv/pep_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_alu
// Multi-cycle Q16.16 arithmetic: add, sub, mul, div, sqrt, sin, cos.
// ----------------------------------------------------------------------------
module pep_alu
  import pep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  alu_op_t            op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] result
);

  alu_state_t state_r, state_nxt;
  alu_op_t    op_r;
  logic [5:0] cnt_r;
  logic signed [31:0] res_r;
  logic signed [63:0] prod_r;
  // divider
  logic [47:0] dvd_r;
  logic [31:0] dvs_r, rem_r;
  logic        neg_r;
  logic [32:0] remsh;
  logic        qbit;
  // sqrt
  logic [47:0] sn_r, sres_r, sbit_r, st, sres_n;
  logic        sge;
  // trig
  logic [MW-1:0] m_r, p_r;
  logic          zneg_r, negc_r;
  logic signed [XW-1:0] x_r, y_r, dx, dy, xo;
  logic signed [ZW-1:0] z_r, z1, z2, z3, at;
  logic                 negc;
  logic [31:0] mag_a, mag_b;

  assign mag_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_b = b[31] ? 32'(-b) : 32'(b);

  assign remsh = {rem_r, dvd_r[47]};
  assign qbit  = (remsh >= {1'b0, dvs_r});

  assign st     = sres_r + sbit_r;
  assign sge    = (sn_r >= st);
  assign sres_n = sge ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);

  assign dx = y_r >>> cnt_r[4:0];
  assign dy = x_r >>> cnt_r[4:0];
  assign at = atan_q24(cnt_r);

  always_comb begin
    z1 = (zneg_r && (m_r != '0)) ? ZW'(TWO_PI_Q24 - m_r) : ZW'(m_r);
    z2 = (z1 > PI_Q24) ? ZW'(z1 - ZW'(TWO_PI_Q24)) : z1;
    negc = 1'b0;
    z3 = z2;
    if (z2 > HALF_PI_Q24) begin
      z3 = PI_Q24 - z2;
      negc = 1'b1;
    end else if (z2 < -HALF_PI_Q24) begin
      z3 = -PI_Q24 - z2;
      negc = 1'b1;
    end
  end

  always_comb begin
    xo = negc_r ? -(x_r >>> 8) : (x_r >>> 8);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AL_IDLE: begin
        if (start) begin
          unique case (op)
            AOP_MUL:           state_nxt = AL_MUL;
            AOP_DIV:           state_nxt = (b == '0) ? AL_DONE : AL_DIV;
            AOP_SQRT:          state_nxt = a[31] ? AL_DONE : AL_SQRT;
            AOP_SIN, AOP_COS:  state_nxt = AL_RED;
            default:           state_nxt = AL_DONE;
          endcase
        end
      end
      AL_MUL:  state_nxt = AL_DONE;
      AL_DIV:  if (cnt_r == '0) state_nxt = AL_QFIN;
      AL_QFIN: state_nxt = AL_DONE;
      AL_SQRT: if (cnt_r == '0) state_nxt = AL_DONE;
      AL_RED:  if (cnt_r == '0) state_nxt = AL_FOLD;
      AL_FOLD: state_nxt = AL_CORD;
      AL_CORD: if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = AL_TFIN;
      AL_TFIN: state_nxt = AL_DONE;
      AL_DONE: state_nxt = AL_IDLE;
      default: state_nxt = AL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (state_r == AL_DONE);
    result = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= AL_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      AL_IDLE: begin
        op_r   <= op;
        prod_r <= 64'(a) * 64'(b);
        dvd_r  <= {mag_a, 16'b0};
        dvs_r  <= mag_b;
        rem_r  <= '0;
        neg_r  <= a[31] ^ b[31];
        sn_r   <= {a[31:0], 16'b0};
        sres_r <= '0;
        sbit_r <= 48'd1 << 46;
        m_r    <= {mag_a, 8'b0};
        zneg_r <= a[31];
        p_r    <= RED_TOP;
        unique case (op)
          AOP_ADD: res_r <= sat32(64'(a) + 64'(b));
          AOP_SUB: res_r <= sat32(64'(a) - 64'(b));
          AOP_DIV: begin
            res_r <= Q_ONE;
            cnt_r <= 6'd47;
          end
          AOP_SQRT: begin
            res_r <= Q_ONE;
            cnt_r <= 6'd23;
          end
          default: cnt_r <= 6'(RED_STEPS - 1);
        endcase
      end
      AL_MUL: res_r <= sat32(prod_r >>> 16);
      AL_DIV: begin
        rem_r <= qbit ? 32'(remsh - {1'b0, dvs_r}) : remsh[31:0];
        dvd_r <= {dvd_r[46:0], qbit};
        cnt_r <= cnt_r - 1'b1;
      end
      AL_QFIN: res_r <= sat32(neg_r ? -$signed({16'b0, dvd_r}) : $signed({16'b0, dvd_r}));
      AL_SQRT: begin
        if (sge) sn_r <= sn_r - st;
        sres_r <= sres_n;
        sbit_r <= sbit_r >> 2;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) res_r <= signed'(sres_n[31:0]);
      end
      AL_RED: begin
        if (m_r >= p_r) m_r <= m_r - p_r;
        p_r   <= p_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      AL_FOLD: begin
        z_r    <= z3;
        negc_r <= negc;
        x_r    <= GAIN_Q24;
        y_r    <= '0;
        cnt_r  <= '0;
      end
      AL_CORD: begin
        if (!z_r[ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      AL_TFIN: res_r <= (op_r == AOP_COS) ? sat32(64'(xo)) : sat32(64'(y_r >>> 8));
      default: ;
    endcase
  end

endmodule

FILE: sv/pep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_back
// Execution side: value stack, variable registers, sequencer, result queue.
// ----------------------------------------------------------------------------
module pep_back
  import pep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  input  tok_t               tok,
  output logic               tok_pop,
  output logic signed [31:0] out_result_value,
  output logic [30:0]        out_abs_error,
  output logic               out_eval_error,
  output logic               out_empty,
  input  logic               out_pop
);

  back_state_t state_r, state_nxt;
  tok_t        tok_r;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic        err_r, err_nxt;

  logic signed [31:0] stack_mem [STACK_DEPTH];
  logic signed [31:0] rd_data_r, wd, b_r, fin_r;
  logic [ADDR_W-1:0]  rd_addr, wa;
  logic               we, b_ld, fin_ld, fin_zero;

  logic signed [31:0] vars_r [NUM_VARS];
  logic               var_ok, var_we;
  logic signed [31:0] var_val;

  logic               alu_start, alu_done;
  logic signed [31:0] alu_a, alu_res;

  res_t               oq_r [OUTQ_DEPTH];
  logic [OQ_PW-1:0]   oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0]   oq_cnt_r;
  logic               oq_full, oq_push, oq_rd;
  res_t               oq_in;
  logic signed [32:0] diff;
  logic [32:0]        mag;

  logic [SP_W-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp_r - 1'b1;
  assign sp_m2 = sp_r - 2'd2;

  assign var_ok  = (32'(tok_r.idx) < 32'(NUM_VARS));
  assign var_val = var_ok ? vars_r[tok_r.idx[VAR_IW-1:0]] : '0;

  assign alu_a = (tok_r.cls == CL_UNA) ? b_r : rd_data_r;

  pep_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (tok_r.aop),
    .a      (alu_a),
    .b      (b_r),
    .done   (alu_done),
    .result (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (tok_valid) state_nxt = B_DEC;
      B_DEC: begin
        unique case (tok_r.cls)
          CL_BIN:  state_nxt = (sp_r < SP_W'(2)) ? B_LAST : B_RDA;
          CL_UNA:  state_nxt = (sp_r == '0) ? B_LAST : B_RDA;
          default: state_nxt = B_LAST;
        endcase
      end
      B_RDA:  state_nxt = B_RDB;
      B_RDB:  state_nxt = B_EXEC;
      B_EXEC: state_nxt = B_WAIT;
      B_WAIT: if (alu_done) state_nxt = B_LAST;
      B_LAST: begin
        if (!tok_r.last) state_nxt = B_IDLE;
        else if (sp_r == '0) state_nxt = B_EMIT;
        else state_nxt = B_LRD;
      end
      B_LRD:  state_nxt = B_EMIT;
      B_EMIT: if (!oq_full) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tok_pop   = 1'b0;
    we        = 1'b0;
    wa        = sp_r[ADDR_W-1:0];
    wd        = tok_r.operand;
    rd_addr   = sp_m1[ADDR_W-1:0];
    b_ld      = 1'b0;
    alu_start = 1'b0;
    var_we    = 1'b0;
    fin_ld    = 1'b0;
    fin_zero  = 1'b0;
    oq_push   = 1'b0;
    sp_nxt    = sp_r;
    err_nxt   = err_r;
    unique case (state_r)
      B_IDLE: tok_pop = tok_valid;
      B_DEC: begin
        unique case (tok_r.cls)
          CL_BIN: if (sp_r < SP_W'(2)) err_nxt = 1'b1;
          CL_UNA: if (sp_r == '0) err_nxt = 1'b1;
          CL_PUSHC, CL_PUSHV: begin
            if (sp_r == SP_W'(STACK_DEPTH)) begin
              err_nxt = 1'b1;
            end else begin
              we     = 1'b1;
              wd     = (tok_r.cls == CL_PUSHC) ? tok_r.operand : var_val;
              sp_nxt = sp_r + 1'b1;
            end
          end
          CL_SETV: var_we = var_ok;
          default: err_nxt = 1'b1;
        endcase
      end
      B_RDB: begin
        rd_addr = sp_m2[ADDR_W-1:0];
        b_ld    = 1'b1;
      end
      B_EXEC: alu_start = 1'b1;
      B_WAIT: begin
        if (alu_done) begin
          we = 1'b1;
          wd = alu_res;
          if (tok_r.cls == CL_BIN) begin
            wa     = sp_m2[ADDR_W-1:0];
            sp_nxt = sp_m1;
          end else begin
            wa = sp_m1[ADDR_W-1:0];
          end
        end
      end
      B_LAST: begin
        if (tok_r.last && sp_r == '0) begin
          err_nxt  = 1'b1;
          fin_zero = 1'b1;
        end
      end
      B_LRD: fin_ld = 1'b1;
      B_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          sp_nxt  = '0;
          err_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      sp_r    <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) tok_r <= tok;
    if (b_ld) b_r <= rd_data_r;
    if (fin_ld) fin_r <= rd_data_r;
    else if (fin_zero) fin_r <= '0;
    if (var_we) vars_r[tok_r.idx[VAR_IW-1:0]] <= tok_r.operand;
  end

  // value stack
  always_ff @(posedge clk) begin
    if (we) stack_mem[wa] <= wd;
    rd_data_r <= stack_mem[rd_addr];
  end

  // result queue
  always_comb begin
    diff = 33'(tok_r.target) - 33'(fin_r);
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    oq_in.value   = fin_r;
    oq_in.abs_err = (mag > 33'h7fffffff) ? 31'h7fffffff : mag[30:0];
    oq_in.err     = err_r;
  end

  assign oq_full  = (oq_cnt_r == OQ_CW'(OUTQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign oq_rd    = out_pop && !out_empty;
  assign out_result_value = oq_r[oq_rp_r].value;
  assign out_abs_error    = oq_r[oq_rp_r].abs_err;
  assign out_eval_error   = oq_r[oq_rp_r].err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wp_r <= oq_wp_r + 1'b1;
      if (oq_rd) oq_rp_r <= oq_rp_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + OQ_CW'(oq_push) - OQ_CW'(oq_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wp_r] <= oq_in;
  end

endmodule

FILE: sv/postfix_expression_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Postfix program evaluator on a Q16.16 value stack with saturation.
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat accepted when
//  --------+-----------------------------------------+--------------------
//  token   | in_opcode/operand_value/var_index/      | in_push & !in_full
//          | target_value/last_token                 |
//  result  | out_result_value/abs_error/eval_error   | out_pop & !out_empty
//
// Token time is set by the sequencer and the iterative arithmetic unit; a
// last token also needs a stack read (unless the stack is empty) and the
// result write. A two-entry token queue takes beats while the back end
// works, and a two-entry result queue lets it go on while out_pop is low.
// Reset (rst_n low, synchronous) empties both queues and the stack; variable
// registers and stack contents are not cleared.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top
  import pep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand_value,
  input  logic [2:0]         in_var_index,
  input  logic signed [31:0] in_target_value,
  input  logic               in_last_token,
  input  logic               in_push,
  output logic               in_full,
  output logic signed [31:0] out_result_value,
  output logic [30:0]        out_abs_error,
  output logic               out_eval_error,
  output logic               out_empty,
  input  logic               out_pop
);

  // decoded tokens from the intake queue
  logic tok_valid, tok_pop;
  tok_t tok;

  pep_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_operand_value (in_operand_value),
    .in_var_index     (in_var_index),
    .in_target_value  (in_target_value),
    .in_last_token    (in_last_token),
    .in_push          (in_push),
    .in_full          (in_full),
    .tok_valid        (tok_valid),
    .tok              (tok),
    .tok_pop          (tok_pop)
  );

  // stack machine, arithmetic unit and result queue
  pep_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (tok_valid),
    .tok              (tok),
    .tok_pop          (tok_pop),
    .out_result_value (out_result_value),
    .out_abs_error    (out_abs_error),
    .out_eval_error   (out_eval_error),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

endmodule
